[design/lpd_pkg.sv]
`timescale 1ns / 1ps

package lpd_pkg;

  localparam int HEADER_BYTES = 4;
  localparam int LEN_W        = 8 * HEADER_BYTES - 1;
  localparam int SHIFT_W      = 8 * (HEADER_BYTES - 1);
  localparam int HCOUNT_W     = $clog2(HEADER_BYTES);

  localparam logic [LEN_W-1:0]    MAX_LEN_RESET = LEN_W'(65536);
  localparam logic [HCOUNT_W-1:0] HCOUNT_LAST   = HCOUNT_W'(HEADER_BYTES - 1);

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_CLOSED  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       new_connection;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

endpackage

[design/length_prefix_deframer.sv]
`timescale 1ns / 1ps

// Throughput: one byte per cycle, sustained, as long as the output is not stalled.
// A result reaches out_valid through the input register, then the framing logic into
// the result register.
// Reset (synchronous, rst_n low) empties both registers, returns the framer to the
// header phase and sets max_len_r to 65536.
module length_prefix_deframer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  lpd_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output lpd_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [lpd_pkg::LEN_W-1:0]     cfg_data
);
  import lpd_pkg::*;

  logic [LEN_W-1:0]    max_len_r;
  logic                in_valid_r;
  in_item_t            in_data_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  phase_t              phase_r, phase_nxt;
  logic [HCOUNT_W-1:0] hcount_r, hcount_nxt;
  logic [SHIFT_W-1:0]  hshift_r, hshift_nxt;
  logic [LEN_W-1:0]    left_r, left_nxt;

  phase_t              ph_cur;
  logic [HCOUNT_W-1:0] hcount_cur;
  logic [SHIFT_W-1:0]  hshift_cur;
  logic [LEN_W-1:0]    left_cur;
  logic [LEN_W:0]      hdr_len;
  logic                hdr_bad;
  logic                left_last;
  logic                out_free;
  logic                fire;
  logic                res_valid;
  out_item_t           res_data;

  // The result register can take a new value when empty or being drained.
  assign out_free  = !out_valid_r || !out_stall;
  assign fire      = in_valid_r && out_free;
  assign in_stall  = in_valid_r && !out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A new-connection byte sees freshly cleared framing state.
  assign ph_cur     = in_data_r.new_connection ? PH_HEADER : phase_r;
  assign hcount_cur = in_data_r.new_connection ? '0 : hcount_r;
  assign hshift_cur = in_data_r.new_connection ? '0 : hshift_r;
  assign left_cur   = in_data_r.new_connection ? '0 : left_r;

  assign hdr_len   = {hshift_cur, in_data_r.in_byte};
  assign hdr_bad   = hdr_len[LEN_W] || (hdr_len[LEN_W-1:0] > max_len_r);
  assign left_last = (left_cur[LEN_W-1:1] == '0);

  always_comb begin
    phase_nxt  = ph_cur;
    hcount_nxt = hcount_cur;
    hshift_nxt = hshift_cur;
    left_nxt   = left_cur;
    case (ph_cur)
      PH_HEADER: begin
        if (hcount_cur != HCOUNT_LAST) begin
          hshift_nxt = {hshift_cur[SHIFT_W-9:0], in_data_r.in_byte};
          hcount_nxt = hcount_cur + 1'b1;
        end else begin
          hcount_nxt = '0;
          hshift_nxt = '0;
          if (hdr_bad) begin
            phase_nxt = PH_CLOSED;
            left_nxt  = '0;
          end else if (hdr_len[LEN_W-1:0] != '0) begin
            phase_nxt = PH_PAYLOAD;
            left_nxt  = hdr_len[LEN_W-1:0];
          end
        end
      end
      PH_PAYLOAD: begin
        if (left_last) begin
          phase_nxt = PH_HEADER;
          left_nxt  = '0;
        end else begin
          left_nxt = left_cur - 1'b1;
        end
      end
      default: begin
        phase_nxt = ph_cur;
      end
    endcase
  end

  always_comb begin
    res_valid         = 1'b0;
    res_data.kind     = KIND_PAYLOAD;
    res_data.out_byte = '0;
    res_data.last     = 1'b0;
    case (ph_cur)
      PH_HEADER: begin
        if (hcount_cur == HCOUNT_LAST) begin
          if (hdr_bad) begin
            res_valid     = 1'b1;
            res_data.kind = KIND_ERROR;
          end else if (hdr_len[LEN_W-1:0] == '0) begin
            res_valid     = 1'b1;
            res_data.kind = KIND_EMPTY;
            res_data.last = 1'b1;
          end
        end
      end
      PH_PAYLOAD: begin
        res_valid         = 1'b1;
        res_data.out_byte = in_data_r.in_byte;
        res_data.last     = left_last;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r   <= MAX_LEN_RESET;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_HEADER;
      hcount_r    <= '0;
      hshift_r    <= '0;
      left_r      <= '0;
    end else begin
      if (cfg_we) begin
        max_len_r <= cfg_data;
      end
      if (in_valid && !in_stall) begin
        in_valid_r <= 1'b1;
      end else if (fire) begin
        in_valid_r <= 1'b0;
      end
      if (out_free) begin
        out_valid_r <= fire && res_valid;
      end
      if (fire) begin
        phase_r  <= phase_nxt;
        hcount_r <= hcount_nxt;
        hshift_r <= hshift_nxt;
        left_r   <= left_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
    if (fire && res_valid) begin
      out_data_r <= res_data;
    end
  end

endmodule
